[sv/periodic_timer_table_assert.svh]
// Assertion macros for the periodic timer table RTL.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef PERIODIC_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_TIMER_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

`define PTT_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define PTT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PTT_ASSERT_IMPLY(lbl, ante, cons, msg)

`define PTT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[sv/ptt_pkg.sv]
// Shared types and constants for the periodic timer table.
// No dependencies; imported by the top level.
package ptt_pkg;

    localparam int DEF_TABLE_SLOTS = 16;
    localparam int DEF_OWNER_BITS  = 8;

    localparam int PORT_OWNER_W = 8;
    localparam int KEY_W        = 32;
    localparam int TIME_W       = 32;
    localparam int IN_DATA_W    = PORT_OWNER_W + KEY_W + TIME_W + TIME_W;
    localparam int OUT_DATA_W   = PORT_OWNER_W + KEY_W;

    typedef enum logic [1:0] {
        REQ_SET    = 2'd0,
        REQ_KILL   = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_TICK   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        KIND_DONE   = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_FIRED  = 2'd2,
        KIND_IDLE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

[sv/ptt_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/periodic_timer_table.sv]
// Periodic timer table: top level, request sequencer and slot scan.
// Depends on ptt_pkg, ptt_ram and periodic_timer_table_assert.svh.
//
// Usage: requests enter on the slave stream (s_tvalid/s_tready, s_tuser holds the
// request type, s_tdata the owner, key, period and current time). Results leave on
// the master stream: m_tuser is the result kind, m_tdata the fired owner and key,
// m_tlast marks the final result of a request. Set, kill and remove-owner give one
// result; a tick gives one result per fired timer in slot order, or a single
// "nothing due" result.
// Timing: every accepted request that is not refused walks all TABLE_SLOTS entries,
// one slot per cycle while no stall holds the scan, through the entry RAM, whose
// registered read is overlapped with the check of the previous slot. The final result
// of a request is pushed from the finish state once the output register is free, and
// the next request is taken when the sequencer is back in idle. A request refused at
// once (owner 0, or key 0 on a set or kill) skips the scan and goes straight to the
// finish state. One request is worked on at a time; s_tready is high whenever the
// sequencer is idle, even while the last result still sits in the output register.
// Reset clears every slot's used bit, so the table starts empty; the entry RAM
// needs no clearing. When the receiver stalls, a tick scan holds at the next due
// slot until the output register frees, so no result is ever lost or reordered.
module periodic_timer_table
    import ptt_pkg::*;
#(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
    parameter int OWNER_BITS  = DEF_OWNER_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // Fields from bit 0 up: owner_handle[7:0], timer_key[31:0], period_ms[31:0],
    // now_time[31:0].
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // Fields from bit 0 up: req_type[1:0].
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // Fields from bit 0 up: fired_owner[7:0], fired_key[31:0].
    output logic [OUT_DATA_W-1:0] m_tdata,
    // Fields from bit 0 up: kind[1:0].
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);

`include "periodic_timer_table_assert.svh"

    // Slot index width and the entry layout in RAM: {owner, key, period, deadline}.
    localparam int IDX_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int ENTRY_W = OWNER_BITS + KEY_W + TIME_W + TIME_W;
    localparam int OWN_EXT = (OWNER_BITS > PORT_OWNER_W) ? OWNER_BITS : PORT_OWNER_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    // Input field extraction.
    logic [PORT_OWNER_W-1:0] in_owner;
    logic [KEY_W-1:0]        in_key;
    logic [TIME_W-1:0]       in_period;
    logic [TIME_W-1:0]       in_now;
    logic [OWN_EXT-1:0]      in_owner_wide;
    logic [OWNER_BITS-1:0]   in_owner_m;

    assign in_owner      = s_tdata[PORT_OWNER_W-1:0];
    assign in_key        = s_tdata[PORT_OWNER_W +: KEY_W];
    assign in_period     = s_tdata[PORT_OWNER_W + KEY_W +: TIME_W];
    assign in_now        = s_tdata[PORT_OWNER_W + KEY_W + TIME_W +: TIME_W];
    assign in_owner_wide = OWN_EXT'(in_owner);
    assign in_owner_m    = in_owner_wide[OWNER_BITS-1:0];

    // Sequencer and request registers.
    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    req_t                    req_op_reg, req_op_next;
    logic                    reject_reg, reject_next;
    logic [OWNER_BITS-1:0]   req_owner_reg, req_owner_next;
    logic [KEY_W-1:0]        req_key_reg, req_key_next;
    logic [TIME_W-1:0]       req_period_reg, req_period_next;
    logic [TIME_W-1:0]       req_now_reg, req_now_next;
    logic                    hit_reg, hit_next;
    logic [IDX_W-1:0]        hit_idx_reg, hit_idx_next;
    logic                    free_reg, free_next;
    logic [IDX_W-1:0]        free_idx_reg, free_idx_next;
    logic [TABLE_SLOTS-1:0]  used_reg, used_next;

    // A fired timer waits here until the scan knows whether it is the final one.
    logic                    pend_valid_reg, pend_valid_next;
    logic [PORT_OWNER_W-1:0] pend_owner_reg, pend_owner_next;
    logic [KEY_W-1:0]        pend_key_reg, pend_key_next;

    // Output register.
    logic                    out_valid_reg, out_valid_next;
    kind_t                   out_kind_reg, out_kind_next;
    logic [PORT_OWNER_W-1:0] out_owner_reg, out_owner_next;
    logic [KEY_W-1:0]        out_key_reg, out_key_next;
    logic                    out_last_reg, out_last_next;

    // RAM port signals.
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]      ram_wdata;
    logic                    ram_re;
    logic [IDX_W-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]      ram_rdata;

    ptt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Decode of the slot currently under check.
    logic [OWNER_BITS-1:0]   ent_owner;
    logic [KEY_W-1:0]        ent_key;
    logic [TIME_W-1:0]       ent_period;
    logic [TIME_W-1:0]       ent_due;
    logic [OWN_EXT-1:0]      ent_owner_wide;
    logic [TIME_W-1:0]       due_diff;
    logic                    ent_used;
    logic                    ent_is_due;

    assign ent_owner      = ram_rdata[ENTRY_W-1 -: OWNER_BITS];
    assign ent_key        = ram_rdata[TIME_W + TIME_W +: KEY_W];
    assign ent_period     = ram_rdata[TIME_W +: TIME_W];
    assign ent_due        = ram_rdata[TIME_W-1:0];
    assign ent_owner_wide = OWN_EXT'(ent_owner);
    assign ent_used       = used_reg[idx_reg];
    // Wrap-safe compare: the deadline has passed when now - due is not negative.
    assign due_diff       = req_now_reg - ent_due;
    assign ent_is_due     = !due_diff[TIME_W-1];

    logic out_free;
    logic fire;
    logic stall;
    logic push;
    kind_t                   push_kind;
    logic [PORT_OWNER_W-1:0] push_owner;
    logic [KEY_W-1:0]        push_key;
    logic                    push_last;
    req_t                    in_op;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        req_op_next     = req_op_reg;
        reject_next     = reject_reg;
        req_owner_next  = req_owner_reg;
        req_key_next    = req_key_reg;
        req_period_next = req_period_reg;
        req_now_next    = req_now_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        used_next       = used_reg;
        pend_valid_next = pend_valid_reg;
        pend_owner_next = pend_owner_reg;
        pend_key_next   = pend_key_reg;

        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = {req_owner_reg, req_key_reg, req_period_reg,
                     req_now_reg + req_period_reg};
        ram_re    = 1'b0;
        ram_raddr = '0;

        push       = 1'b0;
        push_kind  = KIND_DONE;
        push_owner = '0;
        push_key   = '0;
        push_last  = 1'b1;
        fire       = 1'b0;
        stall      = 1'b0;
        in_op      = req_t'(s_tuser);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    // A set with a zero period behaves exactly as a kill.
                    if (in_op == REQ_SET && in_period == '0)
                    begin
                        in_op = REQ_KILL;
                    end
                    req_op_next     = in_op;
                    req_owner_next  = in_owner_m;
                    req_key_next    = in_key;
                    req_period_next = in_period;
                    req_now_next    = in_now;
                    hit_next        = 1'b0;
                    free_next       = 1'b0;
                    pend_valid_next = 1'b0;
                    reject_next     = (in_op != REQ_TICK) &&
                                      ((in_owner_m == '0) ||
                                       (in_op != REQ_REMOVE && in_key == '0));
                    if (reject_next)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                unique case (req_op_reg)
                    REQ_SET, REQ_KILL:
                    begin
                        if (ent_used && ent_owner == req_owner_reg &&
                            ent_key == req_key_reg && !hit_reg)
                        begin
                            hit_next     = 1'b1;
                            hit_idx_next = idx_reg;
                        end
                        if (!ent_used && !free_reg)
                        begin
                            free_next     = 1'b1;
                            free_idx_next = idx_reg;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (ent_used && ent_owner == req_owner_reg)
                        begin
                            used_next[idx_reg] = 1'b0;
                        end
                    end
                    REQ_TICK:
                    begin
                        fire = ent_used && (ent_period != '0) && (ent_owner != '0) &&
                               ent_is_due;
                        if (fire)
                        begin
                            if (pend_valid_reg && !out_free)
                            begin
                                stall = 1'b1;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = {ent_owner, ent_key, ent_period,
                                             req_now_reg + ent_period};
                                if (pend_valid_reg)
                                begin
                                    push       = 1'b1;
                                    push_kind  = KIND_FIRED;
                                    push_owner = pend_owner_reg;
                                    push_key   = pend_key_reg;
                                    push_last  = 1'b0;
                                end
                                pend_valid_next = 1'b1;
                                pend_owner_next = ent_owner_wide[PORT_OWNER_W-1:0];
                                pend_key_next   = ent_key;
                            end
                        end
                    end
                endcase

                // The read of the next slot is issued while this one is checked;
                // a stall keeps the read data register unchanged.
                if (!stall)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_reg + IDX_W'(1);
                        idx_next  = idx_reg + IDX_W'(1);
                    end
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                    if (reject_reg)
                    begin
                        push_kind = KIND_REJECT;
                    end
                    else
                    begin
                        unique case (req_op_reg)
                            REQ_TICK:
                            begin
                                if (pend_valid_reg)
                                begin
                                    push_kind       = KIND_FIRED;
                                    push_owner      = pend_owner_reg;
                                    push_key        = pend_key_reg;
                                    pend_valid_next = 1'b0;
                                end
                                else
                                begin
                                    push_kind = KIND_IDLE;
                                end
                            end
                            REQ_SET:
                            begin
                                // Update the matching entry, else take the lowest free slot.
                                if (hit_reg)
                                begin
                                    ram_we    = 1'b1;
                                    ram_waddr = hit_idx_reg;
                                    push_kind = KIND_DONE;
                                end
                                else if (free_reg)
                                begin
                                    ram_we                  = 1'b1;
                                    ram_waddr               = free_idx_reg;
                                    used_next[free_idx_reg] = 1'b1;
                                    push_kind               = KIND_DONE;
                                end
                                else
                                begin
                                    push_kind = KIND_REJECT;
                                end
                            end
                            REQ_KILL:
                            begin
                                if (hit_reg)
                                begin
                                    used_next[hit_idx_reg] = 1'b0;
                                    push_kind              = KIND_DONE;
                                end
                                else
                                begin
                                    push_kind = KIND_REJECT;
                                end
                            end
                            REQ_REMOVE:
                            begin
                                push_kind = KIND_DONE;
                            end
                        endcase
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: loads on a new result, empties when the receiver takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_owner_next = out_owner_reg;
        out_key_next   = out_key_reg;
        out_last_next  = out_last_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = push_kind;
            out_owner_next = push_owner;
            out_key_next   = push_key;
            out_last_next  = push_last;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            req_op_reg     <= REQ_SET;
            reject_reg     <= 1'b0;
            hit_reg        <= 1'b0;
            free_reg       <= 1'b0;
            used_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            req_op_reg     <= req_op_next;
            reject_reg     <= reject_next;
            hit_reg        <= hit_next;
            free_reg       <= free_next;
            used_reg       <= used_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        req_owner_reg  <= req_owner_next;
        req_key_reg    <= req_key_next;
        req_period_reg <= req_period_next;
        req_now_reg    <= req_now_next;
        hit_idx_reg    <= hit_idx_next;
        free_idx_reg   <= free_idx_next;
        pend_owner_reg <= pend_owner_next;
        pend_key_reg   <= pend_key_next;
        out_kind_reg   <= out_kind_next;
        out_owner_reg  <= out_owner_next;
        out_key_reg    <= out_key_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {out_key_reg, out_owner_reg};
    assign m_tlast  = out_last_reg;

    `PTT_ASSERT_IMPLY(a_nonfired_last, m_tvalid && m_tuser != KIND_FIRED, m_tlast,
        "a result other than a fired timer must end its request")
    `PTT_ASSERT_IMPLY(a_nonfired_zero, m_tvalid && m_tuser != KIND_FIRED, m_tdata == '0,
        "a result other than a fired timer must carry zero owner and key")
    `PTT_ASSERT_IMPLY(a_ram_no_overlap, ram_we && ram_re, ram_waddr != ram_raddr,
        "entry RAM read and write hit the same slot in one cycle")
    `PTT_ASSERT_IMPLY(a_pend_tick, pend_valid_reg, req_op_reg == REQ_TICK,
        "a held fired result exists outside a tick")
    `PTT_ASSERT_NEXT(a_finish_exit, state_reg == ST_FINISH && out_free,
        state_reg == ST_IDLE, "sequencer did not return to idle after its result")

endmodule
